### sv/assert_macros.svh
// Assertion helpers; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication in the same cycle.
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

    localparam int PORT_COUNT_DEF = 4;
    localparam int MAX_DATA       = 6;
    localparam int SET_BYTES      = 20;
    localparam int PORT_STRIDE    = 9;
    localparam int REPLY_LEN      = 35;

    localparam logic [7:0] SYNC_BYTE = 8'hf5;
    localparam logic [7:0] CMD_WRITE = 8'h8a;
    localparam logic [7:0] CMD_READ  = 8'h8b;
    localparam logic [7:0] CMD_REPLY = 8'h8c;
    localparam logic [7:0] TRL_WRITE = 8'h26;
    localparam logic [7:0] TRL_END   = 8'hfa;
    localparam logic [7:0] TRL_REPLY = 8'h27;

    // F5 + 8A + 26 + FA and F5 + 8C + 27 + FA
    localparam logic [15:0] WR_SUM_INIT = 16'h029f;
    localparam logic [15:0] RD_SUM_INIT = 16'h02a2;

    localparam logic [7:0] CODE_LOCAL_IP   = 8'd0;
    localparam logic [7:0] CODE_LOCAL_PORT = 8'd1;
    localparam logic [7:0] CODE_SUBNET     = 8'd2;
    localparam logic [7:0] CODE_GATEWAY    = 8'd3;
    localparam logic [7:0] CODE_MAC        = 8'd4;
    localparam logic [7:0] CODE_REMOTE_IP  = 8'd5;
    localparam logic [7:0] CODE_REMOTE_PRT = 8'd9;
    localparam logic [7:0] CODE_PROTOCOL   = 8'd13;
    localparam logic [7:0] CODE_MODE       = 8'd14;
    localparam logic [7:0] CODE_BAUD       = 8'd15;

    typedef struct packed {
        logic       valid;
        logic       is_port;
        logic [4:0] offset;
    } dst_t;

    typedef struct packed {
        logic       reply;
        logic       commit;
        logic       baud;
        logic [1:0] port;
        logic       is_port;
        logic [4:0] offset;
        logic [2:0] len;
    } req_t;

    function automatic logic [2:0] frame_len(input logic [7:0] code, input logic [2:0] prev);
        logic [2:0] len;
        begin
            case (code) inside
                8'd0, 8'd2, 8'd3, [8'd5:8'd8]: len = 3'd4;
                8'd1, [8'd9:8'd12]:            len = 3'd2;
                8'd4:                          len = 3'd6;
                [8'd13:8'd15]:                 len = 3'd1;
                default:                       len = prev;
            endcase
            return len;
        end
    endfunction

    function automatic dst_t dest_of(input logic [7:0] code);
        dst_t d;
        begin
            d = '0;
            case (code)
                CODE_LOCAL_IP:   d = '{1'b1, 1'b0, 5'd0};
                CODE_LOCAL_PORT: d = '{1'b1, 1'b0, 5'd4};
                CODE_SUBNET:     d = '{1'b1, 1'b0, 5'd6};
                CODE_GATEWAY:    d = '{1'b1, 1'b0, 5'd10};
                CODE_MAC:        d = '{1'b1, 1'b0, 5'd14};
                CODE_REMOTE_IP:  d = '{1'b1, 1'b1, 5'd0};
                CODE_REMOTE_PRT: d = '{1'b1, 1'b1, 5'd4};
                CODE_PROTOCOL:   d = '{1'b1, 1'b1, 5'd6};
                CODE_MODE:       d = '{1'b1, 1'b1, 5'd7};
                CODE_BAUD:       d = '{1'b1, 1'b1, 5'd8};
                default:         d = '0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

### sv/config_frame_parser_unit.sv
// Configuration frame parser for up to four serial ports sharing one parser.
// Each input transaction is one received byte (s_tdata) with the port that
// delivered it (s_tuser); bytes from ports at or above PORT_COUNT are dropped.
// The parser handles each accepted byte as it arrives. A verified write frame
// is committed into the settings RAM one byte per cycle (1 to 6 bytes), and a
// read request F5 8B streams a 35-byte reply out of the same RAM, each byte
// passing a RAM read state and then the output register, so a reply holds off
// input until its last byte is loaded, plus output stalls. Code 15 also emits
// one baud-change transaction with m_tuser high. The settings RAM comes out of
// reset as all zeros through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module config_frame_parser_unit #(
    parameter int PORT_COUNT = cfp_pkg::PORT_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0] s_tuser,   // [1:0] port
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] out_kind
    output logic            m_tlast
);

    localparam int DEPTH  = cfp_pkg::SET_BYTES + cfp_pkg::PORT_STRIDE * PORT_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              busy;
    logic              acc;
    cfp_pkg::req_t     req;
    logic [2:0]        data_idx;
    logic [7:0]        data_byte;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign s_tready = !busy;
    assign acc      = s_tvalid && s_tready && (int'(s_tuser) < PORT_COUNT);

    cfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .rx_byte   (s_tdata),
        .port      (s_tuser),
        .data_idx  (data_idx),
        .data_byte (data_byte),
        .req       (req)
    );

    cfp_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cfp_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .busy      (busy),
        .data_idx  (data_idx),
        .data_byte (data_byte),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### sv/cfp_mem.sv
`default_nettype none

module cfp_mem #(
    parameter int DEPTH  = 56,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'h00;

endmodule

`default_nettype wire

### sv/cfp_parser.sv
`default_nettype none

module cfp_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          acc,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [1:0]    port,
    input  wire logic [2:0]    data_idx,
    output logic      [7:0]    data_byte,
    output cfp_pkg::req_t      req
);

    typedef enum logic [2:0] {
        PH_F5,
        PH_8X,
        PH_DATA,
        PH_26,
        PH_FA,
        PH_SUM
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [2:0]     count_reg, count_next;
    logic [2:0]     flen_reg, flen_next;
    logic [7:0]     code_reg, code_next;
    logic [7:0]     sum_hi_reg, sum_hi_next;
    logic           sum_idx_reg, sum_idx_next;
    logic [15:0]    sum_reg, sum_next;
    logic [7:0]     data_reg [cfp_pkg::MAX_DATA];
    logic           data_we;
    logic [2:0]     data_waddr;
    cfp_pkg::dst_t  dst;

    assign dst        = cfp_pkg::dest_of(code_reg);
    assign data_waddr = count_reg - 3'd1;
    assign data_byte  = data_reg[data_idx];

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        flen_next    = flen_reg;
        code_next    = code_reg;
        sum_hi_next  = sum_hi_reg;
        sum_idx_next = sum_idx_reg;
        sum_next     = sum_reg;
        data_we      = 1'b0;
        req          = '0;
        req.port     = port;
        req.is_port  = dst.is_port;
        req.offset   = dst.offset;
        req.len      = flen_reg;
        if (acc)
        begin
            unique case (phase_reg)
                PH_F5:
                begin
                    if (rx_byte == cfp_pkg::SYNC_BYTE)
                    begin
                        phase_next = PH_8X;
                    end
                end
                PH_8X:
                begin
                    if (rx_byte == cfp_pkg::CMD_WRITE)
                    begin
                        phase_next = PH_DATA;
                        count_next = 3'd0;
                        sum_next   = cfp_pkg::WR_SUM_INIT;
                    end
                    else if (rx_byte == cfp_pkg::CMD_READ)
                    begin
                        req.reply  = 1'b1;
                        phase_next = PH_F5;
                    end
                end
                PH_DATA:
                begin
                    sum_next = sum_reg + {8'h00, rx_byte};
                    if (count_reg == 3'd0)
                    begin
                        code_next = rx_byte;
                        flen_next = cfp_pkg::frame_len(rx_byte, flen_reg);
                    end
                    else if (32'(data_waddr) < cfp_pkg::MAX_DATA)
                    begin
                        data_we = 1'b1;
                    end
                    if (count_reg == flen_next)
                    begin
                        phase_next = PH_26;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_26:
                begin
                    phase_next = (rx_byte == cfp_pkg::TRL_WRITE) ? PH_FA : PH_F5;
                end
                PH_FA:
                begin
                    if (rx_byte == cfp_pkg::TRL_END)
                    begin
                        phase_next   = PH_SUM;
                        sum_idx_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_F5;
                    end
                end
                PH_SUM:
                begin
                    if (!sum_idx_reg)
                    begin
                        sum_hi_next  = rx_byte;
                        sum_idx_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_F5;
                        if (sum_reg == {sum_hi_reg, rx_byte} && dst.valid)
                        begin
                            req.commit = 1'b1;
                            req.baud   = (code_reg == cfp_pkg::CODE_BAUD);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_F5;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_reg[data_waddr] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_F5;
            count_reg   <= 3'd0;
            flen_reg    <= 3'd0;
            code_reg    <= 8'h00;
            sum_hi_reg  <= 8'h00;
            sum_idx_reg <= 1'b0;
            sum_reg     <= 16'h0000;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            flen_reg    <= flen_next;
            code_reg    <= code_next;
            sum_hi_reg  <= sum_hi_next;
            sum_idx_reg <= sum_idx_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

`default_nettype wire

### sv/cfp_seq.sv
`default_nettype none

module cfp_seq #(
    parameter int DEPTH  = 56,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfp_pkg::req_t     req,
    output logic                   busy,
    output logic [2:0]             data_idx,
    input  wire logic [7:0]        data_byte,
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic [7:0]             mem_wdata,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  wire logic [7:0]        mem_rdata,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_kind,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    localparam logic [5:0] POS_SYNC   = 6'd0;
    localparam logic [5:0] POS_CMD    = 6'd1;
    localparam logic [5:0] POS_SET    = 6'd2;
    localparam logic [5:0] POS_PORT   = 6'(2 + cfp_pkg::SET_BYTES);
    localparam logic [5:0] POS_TRL0   = 6'(POS_PORT + cfp_pkg::PORT_STRIDE);
    localparam logic [5:0] POS_TRL1   = 6'(POS_TRL0 + 1);
    localparam logic [5:0] POS_SUM_HI = 6'(POS_TRL0 + 2);
    localparam logic [5:0] POS_SUM_LO = 6'(cfp_pkg::REPLY_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EMIT,
        S_WR,
        S_BAUD
    } state_t;

    state_t            state_reg, state_next;
    logic [5:0]        idx_reg, idx_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [15:0]       sum_reg, sum_next;
    logic [1:0]        port_reg, port_next;
    logic              is_port_reg, is_port_next;
    logic [4:0]        offset_reg, offset_next;
    logic [2:0]        len_reg, len_next;
    logic              baud_reg, baud_next;
    logic              ovalid_reg, ovalid_next;
    logic              okind_reg, okind_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;
    logic              out_free;
    logic              from_mem;
    logic [ADDR_W-1:0] port_base;
    logic [7:0]        reply_byte;

    assign out_free  = !ovalid_reg || out_ready;
    assign port_base = ADDR_W'(cfp_pkg::SET_BYTES)
                     + ADDR_W'(port_reg) * ADDR_W'(cfp_pkg::PORT_STRIDE);
    assign from_mem  = (idx_reg >= POS_SET) && (idx_reg < POS_TRL0);

    assign mem_re    = (state_reg == S_RD) && from_mem;
    assign mem_raddr = (idx_reg < POS_PORT) ? ADDR_W'(idx_reg - POS_SET)
                                            : port_base + ADDR_W'(idx_reg - POS_PORT);
    assign mem_we    = (state_reg == S_WR);
    assign mem_waddr = is_port_reg ? port_base + ADDR_W'(offset_reg) + ADDR_W'(cnt_reg)
                                   : ADDR_W'(offset_reg) + ADDR_W'(cnt_reg);
    assign mem_wdata = data_byte;
    assign data_idx  = (state_reg == S_WR) ? cnt_reg : 3'd0;

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        case (idx_reg)
            POS_SYNC:   reply_byte = cfp_pkg::SYNC_BYTE;
            POS_CMD:    reply_byte = cfp_pkg::CMD_REPLY;
            POS_TRL0:   reply_byte = cfp_pkg::TRL_REPLY;
            POS_TRL1:   reply_byte = cfp_pkg::TRL_END;
            POS_SUM_HI: reply_byte = sum_reg[15:8];
            POS_SUM_LO: reply_byte = sum_reg[7:0];
            default:    reply_byte = mem_rdata;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        port_next    = port_reg;
        is_port_next = is_port_reg;
        offset_next  = offset_reg;
        len_next     = len_reg;
        baud_next    = baud_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        okind_next   = okind_reg;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                port_next    = req.port;
                is_port_next = req.is_port;
                offset_next  = req.offset;
                len_next     = req.len;
                baud_next    = req.baud;
                if (req.reply)
                begin
                    idx_next   = POS_SYNC;
                    sum_next   = cfp_pkg::RD_SUM_INIT;
                    state_next = S_RD;
                end
                else if (req.commit)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_WR;
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b0;
                    obyte_next  = reply_byte;
                    olast_next  = (idx_reg == POS_SUM_LO);
                    if (from_mem)
                    begin
                        sum_next = sum_reg + {8'h00, mem_rdata};
                    end
                    if (idx_reg == POS_SUM_LO)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_RD;
                    end
                end
            end
            S_WR:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == len_reg - 3'd1)
                begin
                    state_next = baud_reg ? S_BAUD : S_IDLE;
                end
            end
            S_BAUD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b1;
                    obyte_next  = data_byte;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= 6'd0;
            cnt_reg     <= 3'd0;
            sum_reg     <= 16'h0000;
            port_reg    <= 2'd0;
            is_port_reg <= 1'b0;
            offset_reg  <= 5'd0;
            len_reg     <= 3'd0;
            baud_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            okind_reg   <= 1'b0;
            obyte_reg   <= 8'h00;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            port_reg    <= port_next;
            is_port_reg <= is_port_next;
            offset_reg  <= offset_next;
            len_reg     <= len_next;
            baud_reg    <= baud_next;
            ovalid_reg  <= ovalid_next;
            okind_reg   <= okind_next;
            obyte_reg   <= obyte_next;
            olast_reg   <= olast_next;
        end
    end

endmodule

`default_nettype wire

### sv/cfp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module cfp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    `CFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output transaction changed while stalled")
    `CFP_ASSERT_NOW(a_baud_last, m_tvalid && m_tuser, m_tlast, "baud change not marked last")
    `CFP_ASSERT_NOW(a_reply_blocks, m_tvalid && !m_tlast, !s_tready, "input accepted inside a reply")
    `CFP_ASSERT_NEXT(a_last_frees, m_tvalid && m_tready && m_tlast, !m_tvalid || !m_tlast || m_tuser || m_tdata != 8'hf5, "reply ended with sync byte")

endmodule

bind config_frame_parser_unit cfp_checker u_cfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/config_frame_parser_check.sv
`timescale 1ns / 100ps

module config_frame_parser_check (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0] s_tuser,   // [1:0] port
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [7:0] out_byte
    input  wire logic       m_tuser,   // [0] out_kind
    input  wire logic       m_tlast,
    output int              fail_count,
    output int              due_count,
    output logic      [2:0] frame_len
);

    localparam int PORTS = cfp_pkg::PORT_COUNT_DEF;

    localparam logic [7:0] CODE_SPARE_HI = 8'd8;
    localparam logic [7:0] CODE_AUX_HI   = 8'd12;

    typedef enum logic [2:0] {
        WAIT_SYNC,
        WAIT_CMD,
        COLLECT_DATA,
        GET_TRL,
        GET_END,
        GET_SUM
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } tx_t;

    tx_t        tx_due [$];
    tx_t        head;

    phase_t     phase;
    logic [2:0] dcount;
    logic [7:0] code;
    logic [7:0] sum_hi;
    logic       sum_idx;
    logic [7:0] dbytes   [cfp_pkg::MAX_DATA];
    logic [7:0] net_cfg  [cfp_pkg::SET_BYTES];
    logic [7:0] port_cfg [cfp_pkg::PORT_STRIDE * PORTS];

    function automatic logic [2:0] code_length(input logic [7:0] c, input logic [2:0] prev);
        if (c == cfp_pkg::CODE_LOCAL_IP || c == cfp_pkg::CODE_SUBNET ||
            c == cfp_pkg::CODE_GATEWAY ||
            (c >= cfp_pkg::CODE_REMOTE_IP && c <= CODE_SPARE_HI))
            return 3'd4;
        if (c == cfp_pkg::CODE_LOCAL_PORT ||
            (c >= cfp_pkg::CODE_REMOTE_PRT && c <= CODE_AUX_HI))
            return 3'd2;
        if (c == cfp_pkg::CODE_MAC)
            return 3'd6;
        if (c >= cfp_pkg::CODE_PROTOCOL && c <= cfp_pkg::CODE_BAUD)
            return 3'd1;
        return prev;
    endfunction

    task automatic push_tx(input logic kind, input logic [7:0] data, input logic last);
        tx_t t;
        t.kind = kind;
        t.data = data;
        t.last = last;
        tx_due.push_back(t);
    endtask

    task automatic queue_reply(input logic [1:0] p);
        logic [7:0] r [cfp_pkg::REPLY_LEN];
        int         sum;
        int         i;
        r[0] = cfp_pkg::SYNC_BYTE;
        r[1] = cfp_pkg::CMD_REPLY;
        for (i = 0; i < cfp_pkg::SET_BYTES; i++)
            r[2 + i] = net_cfg[i];
        for (i = 0; i < cfp_pkg::PORT_STRIDE; i++)
            r[2 + cfp_pkg::SET_BYTES + i] = port_cfg[p * cfp_pkg::PORT_STRIDE + i];
        r[cfp_pkg::REPLY_LEN - 4] = cfp_pkg::TRL_REPLY;
        r[cfp_pkg::REPLY_LEN - 3] = cfp_pkg::TRL_END;
        sum = int'(cfp_pkg::RD_SUM_INIT);
        for (i = 2; i < cfp_pkg::REPLY_LEN - 4; i++)
            sum += r[i];
        r[cfp_pkg::REPLY_LEN - 2] = sum[15:8];
        r[cfp_pkg::REPLY_LEN - 1] = sum[7:0];
        for (i = 0; i < cfp_pkg::REPLY_LEN; i++)
            push_tx(1'b0, r[i], i == cfp_pkg::REPLY_LEN - 1);
    endtask

    task automatic commit_frame(input logic [1:0] p, input logic [7:0] lo);
        int sum;
        int i;
        int n;
        int off;
        bit to_port;
        bit keep;
        n = (frame_len > cfp_pkg::MAX_DATA) ? cfp_pkg::MAX_DATA : int'(frame_len);
        sum = int'(cfp_pkg::WR_SUM_INIT) + int'(code);
        for (i = 0; i < n; i++)
            sum += dbytes[i];
        if (sum != {sum_hi, lo})
            return;
        keep = 1'b1;
        to_port = 1'b0;
        off = 0;
        case (code)
            cfp_pkg::CODE_LOCAL_IP:   off = 0;
            cfp_pkg::CODE_LOCAL_PORT: off = 4;
            cfp_pkg::CODE_SUBNET:     off = 6;
            cfp_pkg::CODE_GATEWAY:    off = 10;
            cfp_pkg::CODE_MAC:        off = 14;
            cfp_pkg::CODE_REMOTE_IP:
            begin
                to_port = 1'b1;
                off = 0;
            end
            cfp_pkg::CODE_REMOTE_PRT:
            begin
                to_port = 1'b1;
                off = 4;
            end
            cfp_pkg::CODE_PROTOCOL:
            begin
                to_port = 1'b1;
                off = 6;
            end
            cfp_pkg::CODE_MODE:
            begin
                to_port = 1'b1;
                off = 7;
            end
            cfp_pkg::CODE_BAUD:
            begin
                to_port = 1'b1;
                off = 8;
            end
            default:                  keep = 1'b0;
        endcase
        if (keep)
        begin
            for (i = 0; i < n; i++)
            begin
                if (to_port)
                    port_cfg[p * cfp_pkg::PORT_STRIDE + off + i] = dbytes[i];
                else
                    net_cfg[off + i] = dbytes[i];
            end
        end
        if (code == cfp_pkg::CODE_BAUD)
            push_tx(1'b1, dbytes[0], 1'b1);
    endtask

    task automatic take_byte(input logic [7:0] b, input logic [1:0] p);
        case (phase)
            WAIT_SYNC:
                if (b == cfp_pkg::SYNC_BYTE)
                    phase = WAIT_CMD;
            WAIT_CMD:
                if (b == cfp_pkg::CMD_WRITE)
                begin
                    phase = COLLECT_DATA;
                    dcount = 3'd0;
                end
                else if (b == cfp_pkg::CMD_READ)
                begin
                    queue_reply(p);
                    phase = WAIT_SYNC;
                end
            COLLECT_DATA:
            begin
                if (dcount == 3'd0)
                begin
                    code = b;
                    frame_len = code_length(b, frame_len);
                end
                else if (dcount <= cfp_pkg::MAX_DATA)
                begin
                    dbytes[dcount - 3'd1] = b;
                end
                if (dcount == frame_len)
                    phase = GET_TRL;
                else
                    dcount = dcount + 3'd1;
            end
            GET_TRL:
                phase = (b == cfp_pkg::TRL_WRITE) ? GET_END : WAIT_SYNC;
            GET_END:
                if (b == cfp_pkg::TRL_END)
                begin
                    phase = GET_SUM;
                    sum_idx = 1'b0;
                end
                else
                begin
                    phase = WAIT_SYNC;
                end
            GET_SUM:
                if (!sum_idx)
                begin
                    sum_hi = b;
                    sum_idx = 1'b1;
                end
                else
                begin
                    commit_frame(p, b);
                    phase = WAIT_SYNC;
                end
            default:
                phase = WAIT_SYNC;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = WAIT_SYNC;
            dcount = 3'd0;
            frame_len = 3'd0;
            code = 8'd0;
            sum_hi = 8'd0;
            sum_idx = 1'b0;
            for (int i = 0; i < cfp_pkg::MAX_DATA; i++)
                dbytes[i] = 8'd0;
            for (int i = 0; i < cfp_pkg::SET_BYTES; i++)
                net_cfg[i] = 8'd0;
            for (int i = 0; i < cfp_pkg::PORT_STRIDE * PORTS; i++)
                port_cfg[i] = 8'd0;
            tx_due.delete();
            fail_count = 0;
            due_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (tx_due.size() == 0)
                begin
                    $error("unexpected output transaction: out_kind %0d out_byte %02h out_last %0d",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    head = tx_due.pop_front();
                    if (m_tuser !== head.kind)
                    begin
                        $error("out_kind expected %0d actual %0d", head.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== head.data)
                    begin
                        $error("out_byte expected %02h actual %02h", head.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head.last)
                    begin
                        $error("out_last expected %0d actual %0d", head.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tuser);
            due_count = tx_due.size();
        end
    end

endmodule

### tb/sv/config_frame_parser_unit_tb.sv
`timescale 1ns / 100ps

module config_frame_parser_unit_tb;

    import cfp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 240;
    localparam int TOTAL_ITEMS = 285;

    localparam logic [7:0] CODE_UNKNOWN = 8'h80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'd0;
    logic [1:0] s_tuser = 2'd0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tuser;
    wire        m_tlast;

    int         fail_count;
    int         due_count;
    logic [2:0] frame_len;

    int         cycles = 0;
    int         sent = 0;
    int         ready_run = 0;
    bit         steady = 1'b0;

    config_frame_parser_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    config_frame_parser_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .due_count  (due_count),
        .frame_len  (frame_len)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // output stalls in random bursts
    always @(negedge clk) begin
        if (steady) begin
            m_tready <= 1'b1;
        end else if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if (m_tready && $urandom_range(0, 2) != 0) begin
            m_tready <= 1'b0;
            ready_run <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
            ready_run <= $urandom_range(0, 60);
        end
    end

    function automatic logic [1:0] stray_port(input logic [1:0] p);
        logic [1:0] q;
        q = $urandom_range(0, 3);
        return ($urandom_range(0, 3) == 0) ? q : p;
    endfunction

    task automatic send(input logic [7:0] b, input logic [1:0] p);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // fill < 0 gives random data bytes
    task automatic send_write(input logic [7:0] c, input logic [1:0] p, input int fill,
                              input bit bad_sum, input bit bad_trl);
        logic [7:0] d;
        logic [7:0] flip;
        int         sum;
        int         n;
        bit         at_end;
        flip = $urandom_range(1, 255);
        at_end = $urandom_range(0, 1);
        sum = WR_SUM_INIT + c;
        send(SYNC_BYTE, stray_port(p));
        send(CMD_WRITE, stray_port(p));
        send(c, stray_port(p));
        n = frame_len;
        repeat (n) begin
            if (fill >= 0)
                d = fill;
            else if (c == CODE_BAUD && $urandom_range(0, 1) == 0)
                d = $urandom_range(0, 5);
            else
                d = $urandom_range(0, 255);
            sum += d;
            send(d, stray_port(p));
        end
        if (bad_trl && !at_end) begin
            send(TRL_WRITE ^ flip, stray_port(p));
            return;
        end
        send(TRL_WRITE, stray_port(p));
        if (bad_trl) begin
            send(TRL_END ^ flip, stray_port(p));
            return;
        end
        send(TRL_END, stray_port(p));
        send(sum[15:8], stray_port(p));
        send(bad_sum ? (sum[7:0] ^ flip) : sum[7:0], p);
    endtask

    task automatic send_read(input logic [1:0] p);
        send(SYNC_BYTE, stray_port(p));
        send(CMD_READ, p);
    endtask

    task automatic random_frame();
        logic [7:0] c;
        logic [1:0] p;
        p = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0)
            c = $urandom_range(CODE_BAUD + 1, 255);
        else
            c = $urandom_range(0, CODE_BAUD);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                send_write(c, p, -1, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            6, 7:
                send_read(p);
            8:
                repeat ($urandom_range(1, 4))
                    send($urandom_range(0, 255), stray_port(p));
            default:
            begin
                send(SYNC_BYTE, p);
                repeat ($urandom_range(1, 3))
                    send($urandom_range(0, 255), stray_port(p));
                if ($urandom_range(0, 1) == 0)
                    send(CMD_READ, p);
            end
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        bit paused;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // read back of the reset settings
        send_read(2'd0);
        // baud code above five, extreme data byte
        send_write(CODE_BAUD, 2'd3, 255, 1'b0, 1'b0);
        // bad second byte before a read
        send(SYNC_BYTE, 2'd1);
        send(8'h33, 2'd1);
        send(CMD_READ, 2'd3);
        // unknown code keeps the previous length
        send_write(CODE_UNKNOWN, 2'd2, 0, 1'b0, 1'b0);
        // broken trailer
        send_write(CODE_PROTOCOL, 2'd0, 0, 1'b0, 1'b1);

        while (sent < RANDOM_ITEMS) begin
            random_frame();
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        steady = 1'b1;
        while (sent < TOTAL_ITEMS)
            random_frame();

        drain();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
